### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the save slot sector validator.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/ssv_pkg.sv
// Package for the save slot sector validator: constants, error codes, check result type.
// No dependencies.
package ssv_pkg;

  localparam int SECTOR_WORDS_DEF = 1024;
  localparam int FOOTER_WORD_DEF  = 1021;
  localparam int SECTIONS         = 14;

  // Word positions: summed length and snapshot points (bytes / 4).
  localparam int SUM_WORDS     = 3968 / 4;
  localparam int SNAP_2000_POS = 2000 / 4 - 1;
  localparam int SNAP_3848_POS = 3848 / 4 - 1;
  localparam int SNAP_3884_POS = 3884 / 4 - 1;

  // Section ids with a shortened checksum.
  localparam logic [15:0] ID_LEN_3884 = 16'd0;
  localparam logic [15:0] ID_LEN_3848 = 16'd4;
  localparam logic [15:0] ID_LEN_2000 = 16'd13;

  localparam logic [31:0] SIGNATURE_RESET = 32'h0801_2025;
  localparam logic [15:0] HALF_MASK       = 16'hFFFF;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_SIGNATURE = 2'd1,
    ERR_RANGE     = 2'd2,
    ERR_DUPLICATE = 2'd3
  } err_t;

  typedef struct packed {
    logic                checksum_ok;
    err_t                first_error;
    logic [SECTIONS-1:0] ids_seen;
  } check_t;

endpackage

### rtl/ssv_footer_check.sv
// Sector footer check: checksum length select, 16-bit fold, error flagging.
// Depends on ssv_pkg.
module ssv_footer_check (
  input  logic [15:0]                   footer_id,
  input  logic [15:0]                   stored_checksum,
  input  logic [31:0]                   running_sum,
  input  logic [31:0]                   sum_at_2000,
  input  logic [31:0]                   sum_at_3848,
  input  logic [31:0]                   sum_at_3884,
  input  logic                          signature_ok,
  input  logic [ssv_pkg::SECTIONS-1:0]  ids_seen,
  input  ssv_pkg::err_t                 first_error,
  output ssv_pkg::check_t               check
);

  logic        in_range;
  logic [31:0] sum_sel;
  logic [15:0] folded;
  logic [ssv_pkg::SECTIONS-1:0] id_bit;

  assign in_range = footer_id < 16'(ssv_pkg::SECTIONS);

  always_comb begin
    if (!in_range) begin
      sum_sel = '0;
    end else begin
      unique case (footer_id)
        ssv_pkg::ID_LEN_3884: sum_sel = sum_at_3884;
        ssv_pkg::ID_LEN_3848: sum_sel = sum_at_3848;
        ssv_pkg::ID_LEN_2000: sum_sel = sum_at_2000;
        default:              sum_sel = running_sum;
      endcase
    end
  end

  // carry of the fold is dropped
  assign folded = (sum_sel[15:0] + sum_sel[31:16]) & ssv_pkg::HALF_MASK;

  assign id_bit = in_range ? (ssv_pkg::SECTIONS)'(1) << footer_id[3:0] : '0;

  always_comb begin
    check.checksum_ok = folded == stored_checksum;
    check.first_error = first_error;
    check.ids_seen    = ids_seen | id_bit;
    // priority: signature, then range, then duplicate; first error sticks
    if (check.first_error == ssv_pkg::ERR_NONE && !signature_ok) begin
      check.first_error = ssv_pkg::ERR_SIGNATURE;
    end
    if (check.first_error == ssv_pkg::ERR_NONE) begin
      if (!in_range) begin
        check.first_error = ssv_pkg::ERR_RANGE;
      end else if ((ids_seen & id_bit) != '0) begin
        check.first_error = ssv_pkg::ERR_DUPLICATE;
      end
    end
  end

endmodule

### rtl/save_slot_sector_validator_top.sv
// Top level of the save slot sector validator: input register, sector state, result register.
// Depends on ssv_pkg, ssv_footer_check and assert_macros.svh.
//
// Usage: the slot image arrives as 32-bit little-endian words on the in_ channel
// (valid/ready, transfer when both high), SECTOR_WORDS words per sector, 14 sectors
// per slot. in_slot_start on a word clears all slot state and takes that word as
// word 0 of sector 0; a partial slot is dropped without a result.
// One result per sector leaves on the out_ channel, built from the sector's last word.
// A word is registered at its input transfer and checked from that register; a sector's
// result loads the output register when the word that ends it leaves the input register.
// Throughput: one word per cycle; the per-word work is one 32-bit add, a few position
// compares and the footer check, all within one register-to-register stage.
// When the receiver stalls, words that give no result keep flowing; a word that ends
// a sector waits in the input register until the output register is free.
// The user must set the footer signature (cfg_we/cfg_wdata) only while idle; not enforced.
// Reset (rst_n low, synchronous) empties both registers, clears all slot state and
// loads the default signature.
module save_slot_sector_validator_top #(
  parameter int SECTOR_WORDS = ssv_pkg::SECTOR_WORDS_DEF,
  parameter int FOOTER_WORD  = ssv_pkg::FOOTER_WORD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic        in_slot_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sector_id,
  output logic        out_checksum_ok,
  output logic [1:0]  out_error_code,
  output logic        out_slot_end,
  output logic        out_slot_valid,
  output logic [31:0] out_min_index
);

  `include "assert_macros.svh"

  localparam int POS_W = $clog2(SECTOR_WORDS);
  localparam int SEC_N = ssv_pkg::SECTIONS;

  // configuration
  logic [31:0] signature_r;

  // input register
  logic        s1_valid_r;
  logic [31:0] s1_word_r;
  logic        s1_start_r;

  // sector and slot state
  logic [POS_W-1:0]    pos_r,    pos_nxt;
  logic [3:0]          cnt_r,    cnt_nxt;
  logic [31:0]         rsum_r,   rsum_nxt;
  logic [31:0]         s2000_r,  s2000_nxt;
  logic [31:0]         s3848_r,  s3848_nxt;
  logic [31:0]         s3884_r,  s3884_nxt;
  logic [15:0]         fid_r,    fid_nxt;
  logic [15:0]         schk_r,   schk_nxt;
  logic                sig_ok_r, sig_ok_nxt;
  logic [SEC_N-1:0]    ids_r,    ids_nxt;
  logic [31:0]         min_r,    min_nxt;
  ssv_pkg::err_t       ferr_r,   ferr_nxt;

  // values after this word's updates, before the sector-end check
  logic [POS_W-1:0]    pos_m;
  logic [3:0]          cnt_m;
  logic [31:0]         rsum_m, s2000_m, s3848_m, s3884_m, min_m;
  logic [15:0]         fid_m, schk_m;
  logic                sig_ok_m;
  logic [SEC_N-1:0]    ids_m;
  ssv_pkg::err_t       ferr_m;
  logic                last_word, slot_last;
  ssv_pkg::check_t     check;

  // output register
  logic          out_valid_r;
  logic [15:0]   out_id_r;
  logic          out_ok_r;
  ssv_pkg::err_t out_err_r;
  logic          out_end_r;
  logic          out_slot_valid_r;
  logic [31:0]   out_index_r;

  logic s1_fire, out_free, emit;

  // a word that ends a sector needs the output register; others never wait
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!last_word || out_free);
  assign emit     = s1_fire && last_word;
  assign in_ready = !s1_valid_r || s1_fire;

  // per-word update: slot clear, running sum, snapshots, footer latches
  always_comb begin
    pos_m    = s1_start_r ? '0 : pos_r;
    cnt_m    = s1_start_r ? '0 : cnt_r;
    rsum_m   = s1_start_r ? '0 : rsum_r;
    s2000_m  = s1_start_r ? '0 : s2000_r;
    s3848_m  = s1_start_r ? '0 : s3848_r;
    s3884_m  = s1_start_r ? '0 : s3884_r;
    fid_m    = s1_start_r ? '0 : fid_r;
    schk_m   = s1_start_r ? '0 : schk_r;
    sig_ok_m = s1_start_r ? 1'b0 : sig_ok_r;
    ids_m    = s1_start_r ? '0 : ids_r;
    min_m    = s1_start_r ? '0 : min_r;
    ferr_m   = s1_start_r ? ssv_pkg::ERR_NONE : ferr_r;

    if (32'(pos_m) < ssv_pkg::SUM_WORDS) begin
      rsum_m = rsum_m + s1_word_r;
      if (32'(pos_m) == ssv_pkg::SNAP_2000_POS) s2000_m = rsum_m;
      if (32'(pos_m) == ssv_pkg::SNAP_3848_POS) s3848_m = rsum_m;
      if (32'(pos_m) == ssv_pkg::SNAP_3884_POS) s3884_m = rsum_m;
    end
    // footer: id and checksum, then signature, then save index
    if (32'(pos_m) == FOOTER_WORD) begin
      fid_m  = s1_word_r[15:0];
      schk_m = s1_word_r[31:16];
    end
    if (32'(pos_m) == FOOTER_WORD + 1) begin
      sig_ok_m = s1_word_r == signature_r;
    end
    if (32'(pos_m) == FOOTER_WORD + 2) begin
      if (cnt_m == '0 || s1_word_r < min_m) min_m = s1_word_r;
    end

    last_word = 32'(pos_m) == SECTOR_WORDS - 1;
    slot_last = 32'(cnt_m) == SEC_N - 1;
  end

  ssv_footer_check u_check (
    .footer_id      (fid_m),
    .stored_checksum(schk_m),
    .running_sum    (rsum_m),
    .sum_at_2000    (s2000_m),
    .sum_at_3848    (s3848_m),
    .sum_at_3884    (s3884_m),
    .signature_ok   (sig_ok_m),
    .ids_seen       (ids_m),
    .first_error    (ferr_m),
    .check          (check)
  );

  // state after the sector end: sector fields clear, slot fields clear on the last sector
  always_comb begin
    pos_nxt    = pos_m + POS_W'(1);
    cnt_nxt    = cnt_m;
    rsum_nxt   = rsum_m;
    s2000_nxt  = s2000_m;
    s3848_nxt  = s3848_m;
    s3884_nxt  = s3884_m;
    fid_nxt    = fid_m;
    schk_nxt   = schk_m;
    sig_ok_nxt = sig_ok_m;
    ids_nxt    = ids_m;
    min_nxt    = min_m;
    ferr_nxt   = ferr_m;
    if (last_word) begin
      pos_nxt    = '0;
      rsum_nxt   = '0;
      s2000_nxt  = '0;
      s3848_nxt  = '0;
      s3884_nxt  = '0;
      fid_nxt    = '0;
      schk_nxt   = '0;
      sig_ok_nxt = 1'b0;
      if (slot_last) begin
        cnt_nxt  = '0;
        ids_nxt  = '0;
        min_nxt  = '0;
        ferr_nxt = ssv_pkg::ERR_NONE;
      end else begin
        cnt_nxt  = cnt_m + 4'd1;
        ids_nxt  = check.ids_seen;
        ferr_nxt = check.first_error;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signature_r <= ssv_pkg::SIGNATURE_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      rsum_r      <= '0;
      s2000_r     <= '0;
      s3848_r     <= '0;
      s3884_r     <= '0;
      fid_r       <= '0;
      schk_r      <= '0;
      sig_ok_r    <= 1'b0;
      ids_r       <= '0;
      min_r       <= '0;
      ferr_r      <= ssv_pkg::ERR_NONE;
    end else begin
      if (cfg_we) begin
        signature_r <= cfg_wdata;
      end
      // input register
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      // sector state
      if (s1_fire) begin
        pos_r    <= pos_nxt;
        cnt_r    <= cnt_nxt;
        rsum_r   <= rsum_nxt;
        s2000_r  <= s2000_nxt;
        s3848_r  <= s3848_nxt;
        s3884_r  <= s3884_nxt;
        fid_r    <= fid_nxt;
        schk_r   <= schk_nxt;
        sig_ok_r <= sig_ok_nxt;
        ids_r    <= ids_nxt;
        min_r    <= min_nxt;
        ferr_r   <= ferr_nxt;
      end
      // output register
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r  <= in_data_word;
      s1_start_r <= in_slot_start;
    end
    if (emit) begin
      out_id_r         <= fid_m;
      out_ok_r         <= check.checksum_ok;
      out_err_r        <= check.first_error;
      out_end_r        <= slot_last;
      out_slot_valid_r <= slot_last && check.first_error == ssv_pkg::ERR_NONE;
      out_index_r      <= min_m;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sector_id   = out_id_r;
  assign out_checksum_ok = out_ok_r;
  assign out_error_code  = out_err_r;
  assign out_slot_end    = out_end_r;
  assign out_slot_valid  = out_slot_valid_r;
  assign out_min_index   = out_index_r;

  // a valid slot is only ever reported on its last sector, with no error
  `ASSERT_IMPL(a_valid_needs_end, clk, rst_n, out_valid_r && out_slot_valid_r,
               out_end_r && out_err_r == ssv_pkg::ERR_NONE)
  // while error-free, each finished sector has added exactly one new id
  `ASSERT_IMPL(a_ids_track_count, clk, rst_n, ferr_r == ssv_pkg::ERR_NONE,
               $countones(ids_r) == 32'(cnt_r))
  // a sector's last word always lands a result in the output register
  `ASSERT_NEXT(a_emit_loads_out, clk, rst_n, emit, out_valid_r)
  // the sector counter never passes the slot length
  `ASSERT_IMPL(a_count_bound, clk, rst_n, s1_fire, 32'(cnt_r) < SEC_N)

endmodule

### verif/save_slot_sector_validator_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for save_slot_sector_validator_top: streams slot images,
// predicts every sector report and compares it field by field.
// Depends on ssv_pkg and the RTL of the validator.
module save_slot_sector_validator_top_test;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 2600;   // long enough for two sector ends to back up
  localparam int SETTLE_CYCLES = 8;    // word in, state update, report register, margin

  // One word of the slot image as the sender offers it.
  typedef struct packed {
    logic [31:0] word;
    logic        start;
  } slot_word_t;

  // One sector report, in the order of the out_ ports.
  typedef struct packed {
    logic [15:0]   sector_id;
    logic          checksum_ok;
    ssv_pkg::err_t error_code;
    logic          slot_end;
    logic          slot_valid;
    logic [31:0]   min_index;
  } sector_report_t;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_SPARSE} fill_t;
  typedef enum logic [1:0] {CS_MATCH, CS_WRONG, CS_GIVEN} csum_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_data_word = '0;
  logic        in_slot_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_sector_id;
  logic        out_checksum_ok;
  logic [1:0]  out_error_code;
  logic        out_slot_end;
  logic        out_slot_valid;
  logic [31:0] out_min_index;

  save_slot_sector_validator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_slot_start   (in_slot_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sector_id   (out_sector_id),
    .out_checksum_ok (out_checksum_ok),
    .out_error_code  (out_error_code),
    .out_slot_end    (out_slot_end),
    .out_slot_valid  (out_slot_valid),
    .out_min_index   (out_min_index)
  );

  // Words waiting to be offered, and reports the predictor says are on their way.
  slot_word_t     image_words[$];
  sector_report_t sector_reports_due[$];

  // Traffic shaping; all but hold_off change only at a falling edge, block idle.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit pressure_armed = 1'b0;
  logic hold_off = 1'b0;

  // Stimulus bookkeeping.
  bit need_start = 1'b1;     // next sector must carry slot_start to realign
  int sectors_queued = 0;

  // Run statistics.
  int cycle_count = 0;
  int fail_count = 0;
  int words_taken = 0;
  int reports_seen = 0;
  int slot_ends_seen = 0;
  int valid_slots_seen = 0;
  int input_backed_up = 0;
  int errs_seen[4] = '{0, 0, 0, 0};

  // Predictor copy of the configuration and of the per-slot state.
  logic [31:0]                  expected_signature = ssv_pkg::SIGNATURE_RESET;
  int                           m_pos = 0;
  int                           m_sector = 0;
  logic [31:0]                  m_sum = '0;
  logic [31:0]                  m_snap_2000 = '0;
  logic [31:0]                  m_snap_3848 = '0;
  logic [31:0]                  m_snap_3884 = '0;
  logic [15:0]                  m_id = '0;
  logic [15:0]                  m_stored = '0;
  logic                         m_sig_ok = 1'b0;
  logic [ssv_pkg::SECTIONS-1:0] m_ids_seen = '0;
  logic [31:0]                  m_min_index = '0;
  ssv_pkg::err_t                m_first_err = ssv_pkg::ERR_NONE;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Checksum as the footer expects it: the id picks which snapshot is summed,
  // ids out of range count as zero, and the halves are added with the carry lost.
  // Shared by the predictor and by the sector builder.
  function automatic logic [15:0] folded_checksum(input logic [15:0] id,
                                                  input logic [31:0] s2000,
                                                  input logic [31:0] s3848,
                                                  input logic [31:0] s3884,
                                                  input logic [31:0] sfull);
    logic [31:0] s;
    if (id >= ssv_pkg::SECTIONS) s = '0;
    else if (id == ssv_pkg::ID_LEN_3884) s = s3884;
    else if (id == ssv_pkg::ID_LEN_3848) s = s3848;
    else if (id == ssv_pkg::ID_LEN_2000) s = s2000;
    else s = sfull;
    return s[15:0] + s[31:16];
  endfunction

  task automatic clear_sector_state();
    m_pos = 0;
    m_sum = '0;
    m_snap_2000 = '0;
    m_snap_3848 = '0;
    m_snap_3884 = '0;
    m_id = '0;
    m_stored = '0;
    m_sig_ok = 1'b0;
  endtask

  task automatic clear_slot_state();
    clear_sector_state();
    m_sector = 0;
    m_ids_seen = '0;
    m_min_index = '0;
    m_first_err = ssv_pkg::ERR_NONE;
  endtask

  // Only the first error of a slot is kept.
  task automatic raise_error(input ssv_pkg::err_t code);
    if (m_first_err == ssv_pkg::ERR_NONE) m_first_err = code;
  endtask

  // Predictor: advance the slot state by one accepted word and queue the sector
  // report when that word closes a sector.
  task automatic absorb_word(input logic [31:0] w, input logic start);
    sector_report_t rep;
    logic           closing;
    if (start) clear_slot_state();
    if (m_pos < ssv_pkg::SUM_WORDS) begin
      m_sum = m_sum + w;
      if (m_pos == ssv_pkg::SNAP_2000_POS) m_snap_2000 = m_sum;
      if (m_pos == ssv_pkg::SNAP_3848_POS) m_snap_3848 = m_sum;
      if (m_pos == ssv_pkg::SNAP_3884_POS) m_snap_3884 = m_sum;
    end
    if (m_pos == ssv_pkg::FOOTER_WORD_DEF) {m_stored, m_id} = w;
    if (m_pos == ssv_pkg::FOOTER_WORD_DEF + 1) m_sig_ok = (w == expected_signature);
    // first sector loads the minimum unconditionally, errors do not block it
    if (m_pos == ssv_pkg::FOOTER_WORD_DEF + 2 && (m_sector == 0 || w < m_min_index))
      m_min_index = w;

    if (m_pos + 1 < ssv_pkg::SECTOR_WORDS_DEF) begin
      m_pos++;
    end else begin
      rep.checksum_ok = (folded_checksum(m_id, m_snap_2000, m_snap_3848, m_snap_3884, m_sum)
                         == m_stored);
      // signature before range before duplicate
      if (!m_sig_ok) raise_error(ssv_pkg::ERR_SIGNATURE);
      if (m_id >= ssv_pkg::SECTIONS) begin
        raise_error(ssv_pkg::ERR_RANGE);
      end else begin
        if (m_ids_seen[m_id[3:0]]) raise_error(ssv_pkg::ERR_DUPLICATE);
        m_ids_seen[m_id[3:0]] = 1'b1;
      end
      closing = (m_sector + 1 >= ssv_pkg::SECTIONS);
      rep.sector_id = m_id;
      rep.error_code = m_first_err;
      rep.slot_end = closing;
      rep.slot_valid = closing && (m_first_err == ssv_pkg::ERR_NONE);
      rep.min_index = m_min_index;
      sector_reports_due.push_back(rep);
      if (closing) begin
        clear_slot_state();
      end else begin
        clear_sector_state();
        m_sector++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders.
  function automatic logic [31:0] filler(input fill_t f);
    case (f)
      FILL_ONES:   return '1;
      FILL_ZEROS:  return '0;
      FILL_SPARSE: return $urandom & $urandom & $urandom;
      default:     return $urandom;
    endcase
  endfunction

  // One complete sector: body, footer {checksum, id}, signature, save index.
  task automatic add_sector(input logic [15:0] id, input fill_t fill, input bit sig_good,
                            input csum_t cs_mode, input logic [15:0] cs_given,
                            input logic [31:0] idx, input bit start);
    logic [31:0] acc, s2000, s3848, s3884, sig_flip;
    logic [15:0] cs, cs_flip;
    slot_word_t  sw;
    int          k;
    acc = '0;
    s2000 = '0;
    s3848 = '0;
    s3884 = '0;
    for (k = 0; k < ssv_pkg::SECTOR_WORDS_DEF; k++) begin
      sw.start = (k == 0) && (start || need_start);
      if (k == ssv_pkg::FOOTER_WORD_DEF) begin
        cs = folded_checksum(id, s2000, s3848, s3884, acc);
        cs_flip = 16'($urandom_range(65535, 1));
        if (cs_mode == CS_WRONG) cs = cs ^ cs_flip;
        else if (cs_mode == CS_GIVEN) cs = cs_given;
        sw.word = {cs, id};
      end else if (k == ssv_pkg::FOOTER_WORD_DEF + 1) begin
        sig_flip = $urandom_range(32'hFFFF_FFFF, 1);
        sw.word = sig_good ? expected_signature : expected_signature ^ sig_flip;
      end else if (k == ssv_pkg::FOOTER_WORD_DEF + 2) begin
        sw.word = idx;
      end else begin
        sw.word = filler(fill);
        if (k < ssv_pkg::SUM_WORDS) acc = acc + sw.word;
        if (k == ssv_pkg::SNAP_2000_POS) s2000 = acc;
        if (k == ssv_pkg::SNAP_3848_POS) s3848 = acc;
        if (k == ssv_pkg::SNAP_3884_POS) s3884 = acc;
      end
      image_words.push_back(sw);
    end
    need_start = 1'b0;
    sectors_queued++;
  endtask

  // Noise: a sector cut short, with the odd stray slot_start.
  task automatic add_partial(input int n);
    slot_word_t sw;
    int         k;
    for (k = 0; k < n; k++) begin
      sw.word = $urandom;
      sw.start = ($urandom_range(99) < 2);
      image_words.push_back(sw);
    end
    need_start = 1'b1;
  endtask

  task automatic load_directed();
    int          k;
    fill_t       f;
    logic [31:0] idx;
    // Clean slot, ids in order; all-ones bodies on the three shortened sums to
    // push carries through every snapshot, index extremes along the way.
    for (k = 0; k < ssv_pkg::SECTIONS; k++) begin
      if (k == 0 || k == 4 || k == 13) f = FILL_ONES;
      else if (k == 1) f = FILL_ZEROS;
      else if (k == 2) f = FILL_SPARSE;
      else f = FILL_RANDOM;
      if (k == 0) idx = 32'h8000_0000;
      else if (k == 1) idx = '1;
      else if (k == 5) idx = '0;
      else idx = $urandom;
      add_sector(16'(k), f, 1'b1, CS_MATCH, '0, idx, k == 0);
    end
    // No slot_start here: the block must have cleared itself after slot end.
    // Bad signature on an out-of-range id: signature is the error that sticks,
    // and a stored checksum of zero still matches.
    add_sector(16'd14, FILL_RANDOM, 1'b0, CS_GIVEN, 16'h0000, '1, 1'b0);
    add_sector(16'hFFFF, FILL_ONES, 1'b1, CS_GIVEN, 16'hFFFF, 32'h1, 1'b0);
    // in-range id with bad signature is still recorded, so its repeat is a duplicate
    add_sector(16'd3, FILL_RANDOM, 1'b0, CS_MATCH, '0, 32'h10, 1'b0);
    add_sector(16'd3, FILL_RANDOM, 1'b1, CS_MATCH, '0, 32'h0, 1'b0);
    add_sector(16'd13, FILL_RANDOM, 1'b1, CS_WRONG, '0, $urandom, 1'b0);
    add_sector(16'd0, FILL_RANDOM, 1'b1, CS_WRONG, '0, $urandom, 1'b0);
    add_sector(16'd4, FILL_RANDOM, 1'b1, CS_MATCH, '0, $urandom, 1'b0);
    for (k = 5; k < 12; k++)
      add_sector(16'(k), FILL_RANDOM, 1'b1, CS_MATCH, '0, $urandom, 1'b0);
    // duplicate as the first error, then the slot is abandoned
    add_sector(16'd5, FILL_RANDOM, 1'b1, CS_MATCH, '0, $urandom, 1'b1);
    add_sector(16'd5, FILL_RANDOM, 1'b1, CS_MATCH, '0, $urandom, 1'b0);
    add_partial(300);
    // range as the first error, then abandoned part way through the footer
    add_sector(16'd40000, FILL_RANDOM, 1'b1, CS_MATCH, '0, $urandom, 1'b1);
    add_partial(ssv_pkg::FOOTER_WORD_DEF + 1);
  endtask

  // Mostly clean slots with random content; the rest carry flaws or are cut short.
  task automatic add_random_slot();
    logic [15:0] order[ssv_pkg::SECTIONS];
    logic [15:0] t, id, cs_given;
    logic [31:0] idx;
    int          k, j, r, style, n_sec;
    fill_t       fill;
    bit          sig_good;
    csum_t       cs_mode;
    for (k = 0; k < ssv_pkg::SECTIONS; k++) order[k] = 16'(k);
    for (k = ssv_pkg::SECTIONS - 1; k > 0; k--) begin
      j = $urandom_range(k, 0);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    style = $urandom_range(99);
    n_sec = (style >= 80) ? $urandom_range(ssv_pkg::SECTIONS - 1, 0) : ssv_pkg::SECTIONS;
    for (k = 0; k < n_sec; k++) begin
      id = order[k];
      sig_good = 1'b1;
      cs_mode = ($urandom_range(99) < 95) ? CS_MATCH : CS_WRONG;
      cs_given = '0;
      r = $urandom_range(99);
      if (r < 85) fill = FILL_RANDOM;
      else if (r < 90) fill = FILL_ONES;
      else if (r < 95) fill = FILL_ZEROS;
      else fill = FILL_SPARSE;
      r = $urandom_range(99);
      if (r < 10) idx = '0;
      else if (r < 20) idx = '1;
      else idx = $urandom;
      if (style >= 60 && style < 80) begin
        r = $urandom_range(99);
        if (r < 20) id = 16'($urandom_range(ssv_pkg::SECTIONS - 1, 0));
        else if (r < 35) id = 16'($urandom_range(65535, ssv_pkg::SECTIONS));
        sig_good = ($urandom_range(99) >= 20);
        case ($urandom_range(3))
          0, 1: cs_mode = CS_MATCH;
          2: cs_mode = CS_WRONG;
          default: begin
            cs_mode = CS_GIVEN;
            cs_given = $urandom_range(1) ? 16'h0000 : 16'($urandom);
          end
        endcase
      end
      add_sector(id, fill, sig_good, cs_mode, cs_given, idx, (k == 0) && $urandom_range(1));
    end
    if (n_sec < ssv_pkg::SECTIONS)
      add_partial($urandom_range(ssv_pkg::SECTOR_WORDS_DEF - 1, 1));
  endtask

  task automatic add_random_sectors(input int target);
    int first;
    first = sectors_queued;
    while (sectors_queued - first < target) add_random_slot();
  endtask

  // Wait until every word has gone in and every report has come out, then give
  // the block time to finish words that close no sector.
  task automatic settle();
    do @(negedge clk);
    while (image_words.size() != 0 || in_valid || sector_reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // New footer signature and idling mix; only called with the block idle.
  task automatic retune(input logic [31:0] sig, input int idle_pct, input int stall_pct);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sig;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    expected_signature = sig;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    need_start = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: prediction happens on the transfer, then the next word is offered.
  // Valid only drops after a transfer, and the payload holds while it waits.
  always @(posedge clk) begin : word_sender
    slot_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_word(in_data_word, in_slot_start);
        words_taken++;
      end
      if (hold_off && in_valid && !in_ready) input_backed_up++;
      if (!in_valid || in_ready) begin
        if (image_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = image_words.pop_front();
          in_valid <= 1'b1;
          in_data_word <= nxt.word;
          in_slot_start <= nxt.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got)
      note_failure($sformatf("report %0d: %s expected %0h, got %0h",
                             reports_seen, name, want, got));
  endtask

  // Receiver: every report transfer is matched against the oldest prediction.
  always @(posedge clk) begin : report_receiver
    sector_report_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sector_reports_due.size() == 0) begin
          note_failure($sformatf("report %0d arrived with none predicted (sector id %0h)",
                                 reports_seen, out_sector_id));
        end else begin
          want = sector_reports_due.pop_front();
          compare_field("sector_id", 32'(want.sector_id), 32'(out_sector_id));
          compare_field("checksum_ok", 32'(want.checksum_ok), 32'(out_checksum_ok));
          compare_field("error_code", 32'(want.error_code), 32'(out_error_code));
          compare_field("slot_end", 32'(want.slot_end), 32'(out_slot_end));
          compare_field("slot_valid", 32'(want.slot_valid), 32'(out_slot_valid));
          compare_field("min_index", want.min_index, out_min_index);
        end
        reports_seen++;
        errs_seen[out_error_code]++;
        if (out_slot_end) slot_ends_seen++;
        if (out_slot_end && out_slot_valid) valid_slots_seen++;
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin : receiver_hold
    wait (pressure_armed);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d reports outstanding",
               cycle_count, sector_reports_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed slots and random slots at full rate under the
  // hold-off, then three more random phases each with its own signature and
  // idling mix.
  initial begin : sequencer
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    pressure_armed = 1'b1;
    load_directed();
    add_random_sectors(ssv_pkg::SECTIONS);
    settle();

    retune(32'h0000_0000, 51, 0);
    add_random_sectors(ssv_pkg::SECTIONS);
    settle();

    retune(32'hFFFF_FFFF, 0, 51);
    add_random_sectors(ssv_pkg::SECTIONS);
    settle();

    retune($urandom, 26, 26);
    add_random_sectors(ssv_pkg::SECTIONS);
    settle();

    $display("Streamed %0d words over %0d sectors: %0d reports, %0d slot ends, %0d valid.",
             words_taken, sectors_queued, reports_seen, slot_ends_seen, valid_slots_seen);
    $display("Error codes none/sig/range/dup: %0d/%0d/%0d/%0d; input backed up %0d cycles.",
             errs_seen[0], errs_seen[1], errs_seen[2], errs_seen[3], input_backed_up);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
